// ===== src/bht_pkg.sv =====
// bht_pkg: constants, codes and shared types of the bucketed hash table
// no dependencies
`default_nettype none
package bht_pkg;

  localparam int NUM_BUCKETS      = 16;
  localparam int SLOTS_PER_BUCKET = 16;
  localparam int TABLE_SIZE       = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int ADDR_W           = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int SLOT_CNT_W       = $clog2(SLOTS_PER_BUCKET + 1);

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int MARK_W   = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
    logic [MARK_W-1:0] mark;
  } entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic need_write;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/bht_ram.sv =====
// bht_ram: generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module bht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/bht_ctrl.sv =====
// bht_ctrl: request sequencing state machine
// depends on bht_pkg
`default_nettype none
module bht_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire bht_pkg::sts_t sts,
  output bht_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_OUT
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid && in_ready_r;
    cmd.issue    = (state_r == S_SCAN);
    cmd.write    = (state_r == S_WRITE);
    cmd.out_load = (state_r == S_OUT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          in_ready_r <= !(in_valid && in_ready_r);
          if (in_valid && in_ready_r) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.done) begin
            state_r <= sts.need_write ? S_WRITE : S_OUT;
          end
        end
        S_WRITE: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (sts.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/bht_dp.sv =====
// bht_dp: request registers, bucket scan, slot store and result register
// depends on bht_pkg and bht_ram
`default_nettype none
module bht_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic        [bht_pkg::KIND_W-1:0]    in_kind,
  input  wire logic        [bht_pkg::KEY_W-1:0]     in_req_key,
  input  wire logic signed [bht_pkg::DATA_W-1:0]    in_req_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic             [bht_pkg::STATUS_W-1:0]  out_status,
  output logic signed      [bht_pkg::DATA_W-1:0]    out_found_data,
  input  wire bht_pkg::cmd_t                        cmd,
  output bht_pkg::sts_t                             sts
);

  localparam int ADDR_W = bht_pkg::ADDR_W;
  localparam int CNT_W  = bht_pkg::SLOT_CNT_W;

  logic [bht_pkg::KIND_W-1:0]   kind_r;
  logic [bht_pkg::KEY_W-1:0]    key_r;
  logic [bht_pkg::DATA_W-1:0]   data_r;
  logic [ADDR_W-1:0]            base_r;
  logic [CNT_W-1:0]             issue_cnt_r;
  logic                         rd_pend_r;
  logic [CNT_W-1:0]             chk_idx_r;
  logic [ADDR_W-1:0]            chk_addr_r;
  logic                         vld_q_r;
  logic [bht_pkg::TABLE_SIZE-1:0] vld_r;
  logic [ADDR_W-1:0]            wr_addr_r;
  bht_pkg::entry_t              wr_entry_r;
  logic [bht_pkg::STATUS_W-1:0] res_status_r;
  logic [bht_pkg::DATA_W-1:0]   res_data_r;
  logic                         out_valid_r;
  logic [bht_pkg::STATUS_W-1:0] out_status_r;
  logic [bht_pkg::DATA_W-1:0]   out_data_r;

  logic [ADDR_W-1:0]            rd_addr;
  logic                         rd_go;
  bht_pkg::entry_t              rd_entry;
  logic [bht_pkg::MARK_W-1:0]   eff_mark;
  logic                         is_ins;
  logic                         is_srch;
  logic                         is_del;
  logic                         ins_hit;
  logic                         match;
  logic                         empty;
  logic                         last;
  logic                         done;
  logic [bht_pkg::STATUS_W-1:0] status_nxt;
  bht_pkg::entry_t              wr_entry_nxt;

  bht_ram #(
    .WIDTH ($bits(bht_pkg::entry_t)),
    .DEPTH (bht_pkg::TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (wr_addr_r),
    .wdata (wr_entry_r),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  assign rd_addr = base_r + ADDR_W'(issue_cnt_r);
  assign rd_go   = cmd.issue && (issue_cnt_r < CNT_W'(bht_pkg::SLOTS_PER_BUCKET));

  assign is_ins  = (kind_r == bht_pkg::KIND_INSERT);
  assign is_srch = (kind_r == bht_pkg::KIND_SEARCH);
  assign is_del  = (kind_r == bht_pkg::KIND_DELETE);

  assign eff_mark = vld_q_r ? rd_entry.mark : bht_pkg::MARK_EMPTY;
  assign ins_hit  = is_ins && (eff_mark != bht_pkg::MARK_USED);
  assign match    = (is_srch || is_del) && (eff_mark == bht_pkg::MARK_USED)
                    && (rd_entry.key == key_r);
  assign empty    = (eff_mark == bht_pkg::MARK_EMPTY);
  assign last     = (chk_idx_r == CNT_W'(bht_pkg::SLOTS_PER_BUCKET - 1));
  assign done     = rd_pend_r && (ins_hit || match || empty || last
                    || !(is_ins || is_srch || is_del));

  always_comb begin
    if (is_ins) begin
      status_nxt = ins_hit ? bht_pkg::ST_DONE : bht_pkg::ST_FULL;
    end else begin
      status_nxt = match ? bht_pkg::ST_DONE : bht_pkg::ST_NOT_FOUND;
    end
    wr_entry_nxt = rd_entry;
    if (is_ins) begin
      wr_entry_nxt.key   = key_r;
      wr_entry_nxt.value = data_r;
      wr_entry_nxt.mark  = bht_pkg::MARK_USED;
    end else begin
      wr_entry_nxt.mark  = bht_pkg::MARK_DELETED;
    end
  end

  always_comb begin
    sts            = '0;
    sts.done       = done;
    sts.need_write = ins_hit || (is_del && match);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // request capture, scan addressing, slot write and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      key_r  <= in_req_key;
      data_r <= in_req_data;
      base_r <= ADDR_W'(32'(in_req_key % 16'(bht_pkg::NUM_BUCKETS))
                * bht_pkg::SLOTS_PER_BUCKET);
    end
    if (rd_go) begin
      chk_idx_r  <= issue_cnt_r;
      chk_addr_r <= rd_addr;
    end
    vld_q_r <= vld_r[rd_addr];
    if (cmd.issue && done) begin
      wr_addr_r    <= chk_addr_r;
      wr_entry_r   <= wr_entry_nxt;
      res_status_r <= status_nxt;
      res_data_r   <= match ? rd_entry.value : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_cnt_r <= '0;
      rd_pend_r   <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        issue_cnt_r <= '0;
        rd_pend_r   <= 1'b0;
      end else begin
        rd_pend_r <= rd_go;
        if (rd_go) begin
          issue_cnt_r <= issue_cnt_r + CNT_W'(1);
        end
      end
      if (cmd.write) begin
        vld_r[wr_addr_r] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_data = out_data_r;

endmodule
`default_nettype wire

// ===== src/bucket_hash_table.sv =====
// bucket_hash_table: top level, controller plus datapath
// depends on bht_pkg, bht_ctrl and bht_dp
// requests: one at a time, each scanning its bucket with a one-slot-per-cycle read
// of the slot ram (1 to 16 slots read per request)
// reset: synchronous active low; all slots read as empty, no clearing pass
`default_nettype none
module bucket_hash_table (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic        [bht_pkg::KIND_W-1:0]  in_kind,
  input  wire logic        [bht_pkg::KEY_W-1:0]   in_req_key,
  input  wire logic signed [bht_pkg::DATA_W-1:0]  in_req_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic             [bht_pkg::STATUS_W-1:0] out_status,
  output logic signed      [bht_pkg::DATA_W-1:0]  out_found_data
);

  bht_pkg::cmd_t cmd;
  bht_pkg::sts_t sts;

  bht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bht_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_kind),
    .in_req_key     (in_req_key),
    .in_req_data    (in_req_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found_data (out_found_data),
    .cmd            (cmd),
    .sts            (sts)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input transfer taken while a request is in flight");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result load did not raise out_valid");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> (!in_ready && !cmd.issue))
    else $error("slot write while idle or scanning");
`endif

endmodule
`default_nettype wire
